>>> rtl/core/tdp_pkg.sv
// shared types and constants for the trial division prime test
package tdp_pkg;

   // width of the request number port
   localparam int REQ_NUMBER_WIDTH = 32;

   // default width of the number under test
   localparam int NUMBER_WIDTH_DEFAULT = 32;

   // request queue between classifier and trial division engine
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_WIDTH = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   // first odd trial divisor and divisor step
   localparam int FIRST_DIVISOR = 3;
   localparam int DIVISOR_STEP = 2;

   // outcome of request classification
   typedef enum logic [1:0] {
      CLS_NOT_PRIME = 2'd0,
      CLS_PRIME     = 2'd1,
      CLS_TRIAL     = 2'd2
   } tdp_class_type;

   // classifier to queue push
   typedef struct packed {
      logic          valid;
      tdp_class_type cls;
   } tdp_push_type;

   // queue occupancy status
   typedef struct packed {
      logic empty;
      logic full;
   } tdp_queue_status_type;

   // divider status towards the engine
   typedef struct packed {
      logic running;
      logic done;
   } tdp_div_status_type;

endpackage

>>> rtl/core/trial_division_prime_test_top.sv
// trial division prime test: one request of one number, one response bit
// numbers below two and even numbers are answered from their classification alone; odd
// numbers run one division per odd divisor tried, on the one-bit-per-cycle divider;
// worst case about sqrt(n) / 2 divisors
// requests are queued two deep; busy is high while the queue is full
// synchronous active-high reset empties the queue and idles the engine
module trial_division_prime_test_top
   import tdp_pkg::*;
#(
   parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [REQ_NUMBER_WIDTH-1:0] req_number,
   output logic                        rsp_valid,
   output logic                        rsp_is_prime
);

   tdp_push_type            push;
   logic [NUMBER_WIDTH-1:0] push_number;
   tdp_queue_status_type    queue_status;
   tdp_class_type           head_cls;
   logic [NUMBER_WIDTH-1:0] head_number;
   logic                    pop;
   logic                    div_start;
   logic [NUMBER_WIDTH-1:0] div_dividend;
   logic [NUMBER_WIDTH-1:0] div_divisor;
   tdp_div_status_type      div_status;
   logic [NUMBER_WIDTH-1:0] div_quotient;
   logic [NUMBER_WIDTH-1:0] div_remainder;

   // request classification
   tdp_front #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_front (
      .start       (start),
      .queue_full  (queue_status.full),
      .req_number  (req_number),
      .busy        (busy),
      .push        (push),
      .push_number (push_number)
   );

   // request queue
   tdp_queue #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_number (push_number),
      .pop         (pop),
      .status      (queue_status),
      .head_cls    (head_cls),
      .head_number (head_number)
   );

   // trial division sequencer
   tdp_back #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_back (
      .clock         (clock),
      .reset         (reset),
      .queue_status  (queue_status),
      .head_cls      (head_cls),
      .head_number   (head_number),
      .pop           (pop),
      .div_start     (div_start),
      .div_dividend  (div_dividend),
      .div_divisor   (div_divisor),
      .div_status    (div_status),
      .div_quotient  (div_quotient),
      .div_remainder (div_remainder),
      .rsp_valid     (rsp_valid),
      .rsp_is_prime  (rsp_is_prime)
   );

   // divider for the trial division sequencer
   tdp_divider #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_divider (
      .clock     (clock),
      .reset     (reset),
      .div_start (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .status    (div_status),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   // reset leaves no response pending and the queue open
   a_reset_clean: assert property (@(posedge clock)
      reset |=> !rsp_valid && !busy)
      else $error("response or busy after reset");

   // a division is never restarted while one is in progress
   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.running)
      else $error("divider started while running");

   // the engine only takes from a non-empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !queue_status.empty)
      else $error("pop from empty queue");

   // a finished division leads to a response or the next divisor
   a_done_followed: assert property (@(posedge clock) disable iff (reset)
      div_status.done |=> rsp_valid || div_status.running)
      else $error("division result dropped");

endmodule

>>> rtl/core/tdp_front.sv
// request classifier: small, even and odd numbers
module tdp_front
   import tdp_pkg::*;
#(
   parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEFAULT
) (
   input  logic                        start,
   input  logic                        queue_full,
   input  logic [REQ_NUMBER_WIDTH-1:0] req_number,
   output logic                        busy,
   output tdp_push_type                push,
   output logic [NUMBER_WIDTH-1:0]     push_number
);

   logic [NUMBER_WIDTH-1:0] number;

   // keep only the bits of the configured width
   assign number = NUMBER_WIDTH'(req_number);
   assign push_number = number;

   // request taken whenever the queue has room
   assign busy = queue_full;
   assign push.valid = start && !queue_full;

   // classify: below two, even, or odd needing trial division
   always_comb begin
      if (number < NUMBER_WIDTH'(2)) begin
         push.cls = CLS_NOT_PRIME;
      end else if (!number[0]) begin
         push.cls = (number == NUMBER_WIDTH'(2)) ? CLS_PRIME : CLS_NOT_PRIME;
      end else begin
         push.cls = CLS_TRIAL;
      end
   end

endmodule

>>> rtl/core/tdp_queue.sv
// short request queue between classifier and trial division engine
module tdp_queue
   import tdp_pkg::*;
#(
   parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tdp_push_type            push,
   input  logic [NUMBER_WIDTH-1:0] push_number,
   input  logic                    pop,
   output tdp_queue_status_type    status,
   output tdp_class_type           head_cls,
   output logic [NUMBER_WIDTH-1:0] head_number
);

   tdp_class_type               cls_ff [QUEUE_DEPTH];
   logic [NUMBER_WIDTH-1:0]     num_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_WIDTH-1:0]  count_ff, count_in;
   logic                        do_push;
   logic                        do_pop;

   assign status.empty = (count_ff == QUEUE_CNT_WIDTH'(0));
   assign status.full  = (count_ff == QUEUE_CNT_WIDTH'(QUEUE_DEPTH));
   assign do_push = push.valid && !status.full;
   assign do_pop  = pop && !status.empty;

   // head entry
   assign head_cls    = cls_ff[rd_ptr_ff];
   assign head_number = num_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + QUEUE_PTR_WIDTH'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + QUEUE_PTR_WIDTH'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_WIDTH'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         cls_ff[wr_ptr_ff] <= push.cls;
         num_ff[wr_ptr_ff] <= push_number;
      end
   end

endmodule

>>> rtl/core/tdp_divider.sv
// restoring divider, one quotient bit per cycle
module tdp_divider
   import tdp_pkg::*;
#(
   parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    div_start,
   input  logic [NUMBER_WIDTH-1:0] dividend,
   input  logic [NUMBER_WIDTH-1:0] divisor,
   output tdp_div_status_type      status,
   output logic [NUMBER_WIDTH-1:0] quotient,
   output logic [NUMBER_WIDTH-1:0] remainder
);

   localparam int CountWidth = (NUMBER_WIDTH > 1) ? $clog2(NUMBER_WIDTH) : 1;

   logic                    running_ff, running_in;
   logic                    done_ff, done_in;
   logic [CountWidth-1:0]   count_ff, count_in;
   logic [NUMBER_WIDTH-1:0] rem_ff, rem_in;
   logic [NUMBER_WIDTH-1:0] quo_ff, quo_in;
   logic [NUMBER_WIDTH-1:0] dvs_ff, dvs_in;
   logic [NUMBER_WIDTH:0]   shifted;
   logic [NUMBER_WIDTH+1:0] diff;
   logic                    fits;
   logic                    last_step;

   assign status.running = running_ff;
   assign status.done    = done_ff;
   assign quotient       = quo_ff;
   assign remainder      = rem_ff;

   // one restoring step: shift in next dividend bit, trial subtract
   assign shifted   = {rem_ff, quo_ff[NUMBER_WIDTH-1]};
   assign diff      = {1'b0, shifted} - {2'b00, dvs_ff};
   assign fits      = !diff[NUMBER_WIDTH+1];
   assign last_step = (count_ff == CountWidth'(NUMBER_WIDTH - 1));

   always_comb begin
      running_in = running_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      dvs_in     = dvs_ff;
      if (div_start) begin
         running_in = 1'b1;
         count_in   = '0;
         rem_in     = '0;
         quo_in     = dividend;
         dvs_in     = divisor;
      end else if (running_ff) begin
         rem_in   = fits ? diff[NUMBER_WIDTH-1:0] : shifted[NUMBER_WIDTH-1:0];
         quo_in   = NUMBER_WIDTH'({quo_ff, fits});
         count_in = count_ff + CountWidth'(1);
         if (last_step) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      count_ff <= count_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dvs_ff   <= dvs_in;
   end

endmodule

>>> rtl/core/tdp_back.sv
// trial division sequencer: walks odd divisors and issues the response
module tdp_back
   import tdp_pkg::*;
#(
   parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tdp_queue_status_type    queue_status,
   input  tdp_class_type           head_cls,
   input  logic [NUMBER_WIDTH-1:0] head_number,
   output logic                    pop,
   output logic                    div_start,
   output logic [NUMBER_WIDTH-1:0] div_dividend,
   output logic [NUMBER_WIDTH-1:0] div_divisor,
   input  tdp_div_status_type      div_status,
   input  logic [NUMBER_WIDTH-1:0] div_quotient,
   input  logic [NUMBER_WIDTH-1:0] div_remainder,
   output logic                    rsp_valid,
   output logic                    rsp_is_prime
);

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_DIVIDE = 2'b10
   } state_type;

   state_type               state_ff, state_in;
   logic [NUMBER_WIDTH-1:0] number_ff, number_in;
   logic [NUMBER_WIDTH-1:0] divisor_ff, divisor_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_is_prime_ff, rsp_is_prime_in;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_prime = rsp_is_prime_ff;
   assign div_dividend = number_in;
   assign div_divisor  = divisor_in;

   // sequencer
   always_comb begin
      state_in        = state_ff;
      number_in       = number_ff;
      divisor_in      = divisor_ff;
      rsp_valid_in    = 1'b0;
      rsp_is_prime_in = rsp_is_prime_ff;
      pop             = 1'b0;
      div_start       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_status.empty) begin
               pop = 1'b1;
               unique case (head_cls)
                  CLS_TRIAL: begin
                     number_in  = head_number;
                     divisor_in = NUMBER_WIDTH'(FIRST_DIVISOR);
                     div_start  = 1'b1;
                     state_in   = ST_DIVIDE;
                  end
                  CLS_PRIME: begin
                     rsp_valid_in    = 1'b1;
                     rsp_is_prime_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in    = 1'b1;
                     rsp_is_prime_in = 1'b0;
                  end
               endcase
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               // divisor above n / divisor: no divisor left, prime
               if (div_quotient < divisor_ff) begin
                  rsp_valid_in    = 1'b1;
                  rsp_is_prime_in = 1'b1;
                  state_in        = ST_IDLE;
               end else if (div_remainder == '0) begin
                  rsp_valid_in    = 1'b1;
                  rsp_is_prime_in = 1'b0;
                  state_in        = ST_IDLE;
               end else begin
                  divisor_in = divisor_ff + NUMBER_WIDTH'(DIVISOR_STEP);
                  div_start  = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      number_ff       <= number_in;
      divisor_ff      <= divisor_in;
      rsp_is_prime_ff <= rsp_is_prime_in;
   end

endmodule

>>> verif/tdp_checker.sv
// response checker for the trial division prime test: predicts and compares each verdict
module tdp_checker
   import tdp_pkg::*;
#(
   parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  logic [REQ_NUMBER_WIDTH-1:0] req_number,
   input  logic                        rsp_valid,
   input  logic                        rsp_is_prime,
   output int                          fail_count,
   output int                          verdicts_pending,
   output int                          prime_count,
   output int                          composite_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // verdicts owed by the block, oldest first, with the number they belong to
   bit                          expected_verdicts[$];
   logic [REQ_NUMBER_WIDTH-1:0] numbers_in_flight[$];

   // trial division over the low NUMBER_WIDTH bits of the request
   function automatic bit prime_by_trial(logic [REQ_NUMBER_WIDTH-1:0] value);
      longint unsigned n;
      longint unsigned divisor;
      n = longint'(value);
      if (NUMBER_WIDTH < 64) begin
         n = n & ((64'd1 << NUMBER_WIDTH) - 64'd1);
      end
      if (n < 2) return 1'b0;
      if (n[0] == 1'b0) return (n == 2);
      // odd divisors while divisor squared stays within n
      for (divisor = FIRST_DIVISOR; divisor <= n / divisor; divisor += DIVISOR_STEP) begin
         if (n % divisor == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   // one line per mismatch, and count it
   task automatic report_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      verdicts_pending = 0;
      prime_count = 0;
      composite_count = 0;
   end

   // watch both channels on the rising edge
   always @(posedge clock) begin
      bit                          want;
      logic [REQ_NUMBER_WIDTH-1:0] tested;
      if (!reset) begin
         // compare a response against the oldest request
         if (rsp_valid === 1'b1) begin
            if (expected_verdicts.size() == 0) begin
               report_mismatch($sformatf("response %b with no request outstanding",
                                         rsp_is_prime));
            end else begin
               want = expected_verdicts.pop_front();
               tested = numbers_in_flight.pop_front();
               if (rsp_is_prime !== want) begin
                  report_mismatch($sformatf("number %0d: is_prime %b, expected %b",
                                            tested, rsp_is_prime, want));
               end
               if (want) prime_count++;
               else composite_count++;
            end
         end
         // accepted request: predict its verdict
         if (start === 1'b1 && busy === 1'b0) begin
            expected_verdicts.push_back(prime_by_trial(req_number));
            numbers_in_flight.push_back(req_number);
         end
      end
      verdicts_pending <= expected_verdicts.size();
   end

endmodule

>>> verif/tb_top.sv
// testbench top for the trial division prime test: stimulus, watchdog and verdict
module tb_top
   import tdp_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_REQUESTS = 78;
   localparam int DRAIN_LIMIT = 2_000_000;

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic [REQ_NUMBER_WIDTH-1:0] req_number;
   logic                        rsp_valid;
   logic                        rsp_is_prime;
   int                          fail_count;
   int                          verdicts_pending;
   int                          prime_count;
   int                          composite_count;

   // burst shaping for the request side
   int burst_left;
   int requests_sent;

   // extremes, the small cases, squares of odd primes and a few slow primes
   localparam logic [31:0] DIRECTED_NUMBERS[22] = '{
      32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd15, 32'd25, 32'd49,
      32'd121, 32'd97, 32'd65521, 32'd65537, 32'd1048573, 32'd16777213,
      32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'h8000_0001,
      32'h5555_5555, 32'hAAAA_AAAB
   };
   localparam int unsigned SMALL_FACTORS[6] = '{2, 3, 5, 7, 11, 13};

   trial_division_prime_test_top i_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_number   (req_number),
      .rsp_valid    (rsp_valid),
      .rsp_is_prime (rsp_is_prime)
   );

   tdp_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_number       (req_number),
      .rsp_valid        (rsp_valid),
      .rsp_is_prime     (rsp_is_prime),
      .fail_count       (fail_count),
      .verdicts_pending (verdicts_pending),
      .prime_count      (prime_count),
      .composite_count  (composite_count)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // random numbers, mostly cheap to test but reaching all 32 bits
   function automatic logic [31:0] draw_number();
      int unsigned pick;
      int unsigned bits;
      int unsigned factor;
      int unsigned other;
      logic [31:0] n;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         // narrow number, prime or not
         bits = $urandom_range(2, 18);
         n = $urandom & ((32'd1 << bits) - 32'd1);
      end else if (pick < 85) begin
         // wide number with a small factor
         factor = SMALL_FACTORS[$urandom_range(0, 5)];
         n = $urandom;
         n = n - n % factor;
      end else begin
         // product of a modest odd number and a wide one
         factor = $urandom_range(1, 511) * 2 + 1;
         other = $urandom_range(factor, 32'hFFFF_FFFF / factor);
         n = factor * other;
      end
      return n;
   endfunction

   // present one request and hold it until taken, then maybe pause
   task automatic send_request(logic [31:0] n);
      int gap;
      start <= 1'b1;
      req_number <= n;
      do @(posedge clock); while (busy !== 1'b0);
      requests_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 7);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            start <= 1'b0;
            req_number <= $urandom;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // watchdog, far beyond the slowest legal run
   initial begin
      #400_000_000;
      $display("timeout with %0d responses outstanding", verdicts_pending);
      $display("TEST FAILED");
      $finish;
   end

   // reset, directed then random requests, drain and verdict
   initial begin
      int drain_cycles;
      reset = 1'b1;
      start = 1'b0;
      req_number = '0;
      burst_left = 0;
      requests_sent = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED_NUMBERS[i]) begin
         send_request(DIRECTED_NUMBERS[i]);
      end
      repeat (RANDOM_REQUESTS) begin
         send_request(draw_number());
      end
      start <= 1'b0;

      // wait for every verdict, then keep watching for strays
      drain_cycles = 0;
      while (verdicts_pending != 0 && drain_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (20) @(posedge clock);

      $display("%0d requests sent: directed extremes and small cases, then random bursts",
               requests_sent);
      $display("verdicts checked: %0d prime, %0d not prime", prime_count, composite_count);
      if (fail_count == 0 && verdicts_pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/tdp_pkg.sv
rtl/core/tdp_front.sv
rtl/core/tdp_queue.sv
rtl/core/tdp_divider.sv
rtl/core/tdp_back.sv
rtl/core/trial_division_prime_test_top.sv
verif/tdp_checker.sv
verif/tb_top.sv
